// ===== rtl/core/vca_pkg.sv =====
`timescale 1ns / 1ps
package vca_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int PROBE_LIMIT_DEF = 8;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int COORD_W  = 21;
    localparam int SLOT_W   = 12;
    localparam int CNT_W    = 24;
    localparam int OCC_W    = 13;
    localparam int STATUS_W = 3;
    localparam int EDGE_W   = 16;
    localparam int KEY_W    = 3 * COORD_W;
    localparam int SUM_W    = 46;

    localparam logic [31:0] HASH_ADD = 32'h9e3779b9;
    localparam logic [15:0] EDGE_RESET = 16'd80;

    typedef enum logic [2:0] {
        ST_MERGED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_SATURATED = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_OCCUPIED  = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_ADD  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    localparam logic [1:0] REG_EDGE = 2'd0;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV,
        FS_HASH,
        FS_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_PROBE_RD,
        BS_PROBE_CHK,
        BS_SUM_RD,
        BS_SUM_WR,
        BS_READ_RD,
        BS_READ_DIV,
        BS_OUT
    } back_state_t;

    // one classified command, front to back
    typedef struct packed {
        logic                     func;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [KEY_W-1:0]          key;
        logic [31:0]               hash;
        logic [SLOT_W-1:0]         read_slot;
    } cmd_t;

    function automatic logic [31:0] hash_combine(input logic [31:0] h, input logic [31:0] k);
        return h ^ (k + HASH_ADD + (h << 6) + (h >> 2));
    endfunction

endpackage

// ===== rtl/core/vca_if.sv =====
`timescale 1ns / 1ps
interface vca_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [20:0] x_mm;
    logic [20:0] y_mm;
    logic [20:0] z_mm;
    logic [11:0] read_slot;
    modport source (output valid, func, x_mm, y_mm, z_mm, read_slot, input ready);
    modport sink (input valid, func, x_mm, y_mm, z_mm, read_slot, output ready);
endinterface

interface vca_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] slot;
    logic [23:0] point_count;
    logic [20:0] centroid_x;
    logic [20:0] centroid_y;
    logic [20:0] centroid_z;
    logic [12:0] occupied_voxels;
    modport source (output valid, status, slot, point_count, centroid_x, centroid_y,
                    centroid_z, occupied_voxels, input ready);
    modport sink (input valid, status, slot, point_count, centroid_x, centroid_y,
                  centroid_z, occupied_voxels, output ready);
endinterface

// ===== rtl/core/vca_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
module vca_divider #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            n_next    = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one bit, subtract when it fits
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DEN_W-1:0];
endmodule

// ===== rtl/core/vca_front.sv =====
`timescale 1ns / 1ps
// Accept items; for an add, floor-divide the point by the voxel edge and hash the key. A read passes straight through.
module vca_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         edge_mm,
    vca_in_if.sink              in_ch,
    output vca_pkg::cmd_t       cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready
);
    import vca_pkg::*;

    front_state_t     state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [1:0]       axis_reg, axis_next;
    logic [COORD_W-1:0] k_reg [3];
    logic             kick_reg;
    logic [15:0]      den;
    logic             div_start;
    logic [COORD_W-1:0] div_num;
    logic             div_done;
    logic [COORD_W-1:0] div_q;
    logic [15:0]      div_r;
    logic signed [COORD_W-1:0] p_cur;
    logic [COORD_W-1:0] kq;
    logic [31:0]      h;

    assign den = (edge_mm == 16'd0) ? 16'd1 : edge_mm;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    p_cur = cmd_reg.px;
            2'd1:    p_cur = cmd_reg.py;
            default: p_cur = cmd_reg.pz;
        endcase
    end

    assign div_num = p_cur[COORD_W-1] ? COORD_W'(-p_cur) : p_cur;

    vca_divider #(.NUM_W(COORD_W), .DEN_W(16)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(den),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    // floor of a negative quotient: negate and step down on a remainder
    always_comb
    begin
        if (p_cur[COORD_W-1])
            kq = COORD_W'(-div_q) - ((div_r != 16'd0) ? COORD_W'(1) : COORD_W'(0));
        else
            kq = div_q;
    end

    always_comb
    begin
        h = hash_combine(hash_combine({{11{k_reg[0][COORD_W-1]}}, k_reg[0]},
                                      {{11{k_reg[1][COORD_W-1]}}, k_reg[1]}),
                         {{11{k_reg[2][COORD_W-1]}}, k_reg[2]});
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        axis_next  = axis_reg;
        in_ch.ready = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    cmd_next.func      = in_ch.func;
                    cmd_next.px        = in_ch.x_mm;
                    cmd_next.py        = in_ch.y_mm;
                    cmd_next.pz        = in_ch.z_mm;
                    cmd_next.read_slot = in_ch.read_slot;
                    cmd_next.key       = '0;
                    cmd_next.hash      = '0;
                    axis_next          = 2'd0;
                    state_next = (in_ch.func == FUNC_READ) ? FS_PUSH : FS_DIV;
                end
            end
            FS_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                        state_next = FS_HASH;
                    else
                        axis_next = axis_reg + 2'd1;
                end
            end
            FS_HASH:
            begin
                cmd_next.key  = {k_reg[2], k_reg[1], k_reg[0]};
                cmd_next.hash = h;
                state_next    = FS_PUSH;
            end
            FS_PUSH:
            begin
                if (cmd_ready)
                    state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    // kick the divider on entry to each axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            kick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kick_reg  <= (state_next == FS_DIV) &&
                         (state_reg != FS_DIV || div_done);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        axis_reg <= axis_next;
        if (div_done)
            k_reg[axis_reg] <= kq;
    end

    assign div_start = kick_reg;
    assign cmd       = cmd_reg;
    assign cmd_valid = (state_reg == FS_PUSH);
endmodule

// ===== rtl/core/vca_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module vca_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  vca_pkg::cmd_t in_cmd,
    input  logic          in_valid,
    output logic          in_ready,
    output vca_pkg::cmd_t out_cmd,
    output logic          out_valid,
    input  logic          out_ready
);
    import vca_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("queue lost an entry");
endmodule

// ===== rtl/core/vca_back.sv =====
`timescale 1ns / 1ps
// Probe the table, update sums and counts, answer reads.
module vca_back #(
    parameter int TABLE_DEPTH = vca_pkg::TABLE_DEPTH_DEF,
    parameter int PROBE_LIMIT = vca_pkg::PROBE_LIMIT_DEF,
    parameter int COUNT_BITS  = vca_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  vca_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    vca_out_if.source     out_ch
);
    import vca_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PRB_W = $clog2(PROBE_LIMIT + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // table memories
    logic [KEY_W-1:0]      key_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];
    logic                  vld_mem [TABLE_DEPTH];
    logic [SUM_W-1:0]      sum_mem [3*TABLE_DEPTH];

    back_state_t state_reg, state_next;
    cmd_t        c_reg;
    logic [IDX_W-1:0] home_reg, s_reg;
    logic [PRB_W-1:0] probe_reg;
    logic [1:0]  ax_reg;
    logic [IDX_W:0] clr_reg;
    logic [OCC_W-1:0] occ_reg;
    logic        clearing;
    logic        rd_hit;

    logic [KEY_W-1:0]      key_rd;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic                  vld_rd;
    logic [SUM_W-1:0]      sum_rd;

    logic [STATUS_W-1:0] o_status_reg;
    logic [SLOT_W-1:0]   o_slot_reg;
    logic [CNT_W-1:0]    o_cnt_reg;
    logic [COORD_W-1:0]  o_cen_reg [3];
    logic                o_valid_reg;

    logic div_start, div_done;
    logic [SUM_W-1:0] div_num, div_q;
    logic [COUNT_BITS-1:0] div_r;

    logic signed [COORD_W-1:0] pax;
    logic [$clog2(3*TABLE_DEPTH)-1:0] sum_addr;

    assign clearing = !clr_reg[IDX_W];
    assign cmd_ready = (state_reg == BS_IDLE) && !clearing && !o_valid_reg;

    // occupied slot inside the table
    assign rd_hit = vld_rd && (cnt_rd != '0) &&
                    (32'(c_reg.read_slot) < 32'(TABLE_DEPTH));

    always_comb
    begin
        unique case (ax_reg)
            2'd0:    pax = c_reg.px;
            2'd1:    pax = c_reg.py;
            default: pax = c_reg.pz;
        endcase
    end

    assign sum_addr = ($clog2(3*TABLE_DEPTH))'(3 * s_reg) + ($clog2(3*TABLE_DEPTH))'(ax_reg);
    assign div_num  = sum_rd[SUM_W-1] ? (SUM_W)'(-sum_rd) : sum_rd;

    vca_divider #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(cnt_rd),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            BS_IDLE:
                if (cmd_valid && cmd_ready)
                    state_next = BS_PROBE_RD;
            BS_PROBE_RD:
                state_next = (c_reg.func == FUNC_READ) ? BS_READ_RD : BS_PROBE_CHK;
            BS_PROBE_CHK:
                if (!vld_rd || key_rd == c_reg.key)
                    state_next = (!vld_rd || cnt_rd != CNT_MAX) ? BS_SUM_RD : BS_OUT;
                else if (probe_reg == PRB_W'(PROBE_LIMIT - 1))
                    state_next = BS_OUT;
                else
                    state_next = BS_PROBE_RD;
            BS_SUM_RD:    state_next = BS_SUM_WR;
            BS_SUM_WR:    state_next = (ax_reg == 2'd2) ? BS_OUT : BS_SUM_RD;
            BS_READ_RD:
                state_next = rd_hit ? BS_SUM_RD : BS_OUT;
            BS_READ_DIV:
                if (div_done)
                    state_next = (ax_reg == 2'd2) ? BS_OUT : BS_SUM_RD;
            BS_OUT:       state_next = BS_IDLE;
            default:      state_next = BS_IDLE;
        endcase
        if (state_reg == BS_SUM_WR && c_reg.func == FUNC_READ)
        begin
            div_start  = 1'b1;
            state_next = BS_READ_DIV;
        end
    end

    // registered reads of the current slot, each taken from s_reg in the cycle before
    always_ff @(posedge clk)
    begin
        key_rd <= key_mem[s_reg];
        cnt_rd <= cnt_mem[s_reg];
        sum_rd <= sum_mem[sum_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BS_IDLE;
            clr_reg      <= '0;
            occ_reg      <= '0;
            o_valid_reg  <= 1'b0;
            vld_rd       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_rd    <= clearing ? 1'b0 : vld_mem[s_reg];
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (o_valid_reg && out_ch.ready)
                o_valid_reg <= 1'b0;
            if (state_reg == BS_OUT)
                o_valid_reg <= 1'b1;
            if (state_reg == BS_PROBE_CHK && !vld_rd)
                occ_reg <= occ_reg + 1'b1;
        end
    end

    // valid bits: cleared by a sweep after reset
    always_ff @(posedge clk)
    begin
        if (clearing)
            vld_mem[clr_reg[IDX_W-1:0]] <= 1'b0;
        else if (state_reg == BS_PROBE_CHK && !vld_rd)
            vld_mem[s_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BS_IDLE:
                if (cmd_valid && cmd_ready)
                begin
                    c_reg     <= cmd;
                    home_reg  <= cmd.hash[IDX_W-1:0];
                    s_reg     <= (cmd.func == FUNC_READ) ? IDX_W'(cmd.read_slot)
                                                         : cmd.hash[IDX_W-1:0];
                    probe_reg <= '0;
                    ax_reg    <= 2'd0;
                    o_cen_reg[0] <= '0;
                    o_cen_reg[1] <= '0;
                    o_cen_reg[2] <= '0;
                end
            BS_PROBE_CHK:
            begin
                if (!vld_rd)
                begin
                    key_mem[s_reg] <= c_reg.key;
                    cnt_mem[s_reg] <= COUNT_BITS'(1);
                    o_status_reg   <= ST_NEW;
                    o_cnt_reg      <= CNT_W'(1);
                    o_slot_reg     <= SLOT_W'(s_reg);
                end
                else if (key_rd == c_reg.key)
                begin
                    o_slot_reg <= SLOT_W'(s_reg);
                    if (cnt_rd == CNT_MAX)
                    begin
                        o_status_reg <= ST_SATURATED;
                        o_cnt_reg    <= CNT_W'(cnt_rd);
                    end
                    else
                    begin
                        cnt_mem[s_reg] <= cnt_rd + 1'b1;
                        o_status_reg   <= ST_MERGED;
                        o_cnt_reg      <= CNT_W'(cnt_rd + 1'b1);
                    end
                end
                else if (probe_reg == PRB_W'(PROBE_LIMIT - 1))
                begin
                    o_status_reg <= ST_FULL;
                    o_slot_reg   <= SLOT_W'(home_reg);
                    o_cnt_reg    <= '0;
                end
                else
                begin
                    probe_reg <= probe_reg + 1'b1;
                    s_reg     <= s_reg + 1'b1;
                end
            end
            BS_SUM_WR:
            begin
                if (c_reg.func == FUNC_ADD)
                begin
                    sum_mem[sum_addr] <= (o_status_reg == ST_NEW)
                        ? SUM_W'(pax) : sum_rd + SUM_W'(pax);
                    ax_reg <= ax_reg + 2'd1;
                end
            end
            BS_READ_RD:
            begin
                o_slot_reg <= c_reg.read_slot;
                if (rd_hit)
                begin
                    o_status_reg <= ST_OCCUPIED;
                    o_cnt_reg    <= CNT_W'(cnt_rd);
                end
                else
                begin
                    o_status_reg <= ST_EMPTY;
                    o_cnt_reg    <= '0;
                end
            end
            BS_READ_DIV:
                if (div_done)
                begin
                    o_cen_reg[ax_reg] <= sum_rd[SUM_W-1] ? COORD_W'(-div_q) : COORD_W'(div_q);
                    ax_reg <= ax_reg + 2'd1;
                end
            default: ;
        endcase
    end

    assign out_ch.valid           = o_valid_reg;
    assign out_ch.status          = o_status_reg;
    assign out_ch.slot            = o_slot_reg;
    assign out_ch.point_count     = o_cnt_reg;
    assign out_ch.centroid_x      = o_cen_reg[0];
    assign out_ch.centroid_y      = o_cen_reg[1];
    assign out_ch.centroid_z      = o_cen_reg[2];
    assign out_ch.occupied_voxels = occ_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !out_ch.ready) |=> o_valid_reg)
        else $error("result dropped before taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !cmd_ready)
        else $error("command taken during clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= 32'(TABLE_DEPTH))
        else $error("occupancy beyond table");
endmodule

// ===== rtl/core/voxel_centroid_accumulator_top.sv =====
`timescale 1ns / 1ps
// Voxel-grid centroid accumulator. An add point is floor-divided by the voxel
// edge on each axis in the front divider, then the back sequencer probes slots
// and updates the sums; a read divides each sum by the count in the back divider
// (sum / count). After reset the back end sweeps the valid bits of every table
// slot before it takes any item.
// The front can hash the next point while the back works on the current one.
module voxel_centroid_accumulator_top #(
    parameter int TABLE_DEPTH = vca_pkg::TABLE_DEPTH_DEF,
    parameter int PROBE_LIMIT = vca_pkg::PROBE_LIMIT_DEF,
    parameter int COUNT_BITS  = vca_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    vca_in_if.sink      in_ch,
    vca_out_if.source   out_ch
);
    import vca_pkg::*;

    logic [15:0] edge_reg;
    cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_EDGE) ? {16'd0, edge_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_reg <= EDGE_RESET;
        else if (psel && penable && pwrite && paddr == REG_EDGE)
            edge_reg <= pwdata[15:0];
    end

    vca_front u_front (
        .clk(clk), .rst_n(rst_n), .edge_mm(edge_reg), .in_ch(in_ch),
        .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
    );

    vca_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_cmd(f_cmd), .in_valid(f_valid), .in_ready(f_ready),
        .out_cmd(q_cmd), .out_valid(q_valid), .out_ready(q_ready)
    );

    vca_back #(.TABLE_DEPTH(TABLE_DEPTH), .PROBE_LIMIT(PROBE_LIMIT),
               .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
        .out_ch(out_ch)
    );
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import vca_pkg::*;

    localparam int DEPTH = 4096;
    localparam int PROBES = 8;
    localparam int CMAX = (1 << 24) - 1;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] slot;
        logic [23:0] point_count;
        logic [20:0] cx;
        logic [20:0] cy;
        logic [20:0] cz;
        logic [12:0] occupied;
    } voxel_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vca_in_if in_ch();
    vca_out_if out_ch();

    voxel_centroid_accumulator_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // predictor state
    logic [15:0] edge_mm;
    bit          vox_valid[DEPTH];
    logic [62:0] vox_key[DEPTH];
    longint      vox_sum[3*DEPTH];
    int          vox_count[DEPTH];
    int          vox_total;

    voxel_result_t centroid_queue[$];
    int  errors;
    int  idle_cycles;
    bit  hold_off;
    bit  last_part;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int floor_div(int a, int d);
        int q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] mix(logic [31:0] h, logic [31:0] k);
        return h ^ (k + 32'h9e3779b9 + (h << 6) + (h >> 2));
    endfunction

    // compute the expected result and advance the predictor state
    function automatic voxel_result_t predict_voxel(logic f, logic signed [20:0] x,
        logic signed [20:0] y, logic signed [20:0] z, logic [11:0] rs);
        voxel_result_t r;
        int p[3];
        int k[3];
        int e;
        int home;
        int s;
        logic [62:0] key;
        logic [31:0] h;
        bit done;
        r = '0;
        if (f == FUNC_ADD)
        begin
            e = (edge_mm == 0) ? 1 : int'(edge_mm);
            p[0] = x;
            p[1] = y;
            p[2] = z;
            for (int j = 0; j < 3; j++)
                k[j] = floor_div(p[j], e);
            key = {k[2][20:0], k[1][20:0], k[0][20:0]};
            h = mix(mix(k[0], k[1]), k[2]);
            home = h % DEPTH;
            r.status = ST_FULL;
            r.slot = 12'(home);
            done = 0;
            for (int i = 0; i < PROBES && !done; i++)
            begin
                s = (home + i) % DEPTH;
                if (!vox_valid[s])
                begin
                    vox_valid[s] = 1;
                    vox_key[s] = key;
                    for (int j = 0; j < 3; j++)
                        vox_sum[3*s+j] = p[j];
                    vox_count[s] = 1;
                    vox_total++;
                    r.status = ST_NEW;
                    r.slot = 12'(s);
                    r.point_count = 24'd1;
                    done = 1;
                end
                else if (vox_key[s] == key)
                begin
                    r.slot = 12'(s);
                    if (vox_count[s] >= CMAX)
                        r.status = ST_SATURATED;
                    else
                    begin
                        for (int j = 0; j < 3; j++)
                            vox_sum[3*s+j] += p[j];
                        vox_count[s]++;
                        r.status = ST_MERGED;
                    end
                    r.point_count = 24'(vox_count[s]);
                    done = 1;
                end
            end
        end
        else
        begin
            s = rs;
            r.slot = rs;
            r.status = ST_EMPTY;
            if (vox_valid[s] && vox_count[s] != 0)
            begin
                r.status = ST_OCCUPIED;
                r.point_count = 24'(vox_count[s]);
                r.cx = 21'(vox_sum[3*s] / longint'(vox_count[s]));
                r.cy = 21'(vox_sum[3*s+1] / longint'(vox_count[s]));
                r.cz = 21'(vox_sum[3*s+2] / longint'(vox_count[s]));
            end
        end
        r.occupied = 13'(vox_total);
        return r;
    endfunction

    // send one beat, predicting at acceptance; valid stays up for the next beat
    task automatic send_item(logic f, logic [20:0] x, logic [20:0] y, logic [20:0] z,
        logic [11:0] rs);
        if (!last_part && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.x_mm <= x;
        in_ch.y_mm <= y;
        in_ch.z_mm <= z;
        in_ch.read_slot <= rs;
        do
            @(posedge clk);
        while (!in_ch.ready);
        centroid_queue.insert(centroid_queue.size(), predict_voxel(f, x, y, z, rs));
    endtask

    task automatic add_point(int x, int y, int z);
        send_item(FUNC_ADD, x[20:0], y[20:0], z[20:0], 12'($urandom));
    endtask

    task automatic read_slot(int s);
        send_item(FUNC_READ, 21'($urandom), 21'($urandom), 21'($urandom), s[11:0]);
    endtask

    // drop valid and wait for every expected result
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (centroid_queue.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_edge(logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_EDGE;
        pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        edge_mm = v;
    endtask

    function automatic int rand_coord();
        return $signed(21'($urandom));
    endfunction

    task automatic test_directed;
        add_point(0, 0, 0);
        add_point(79, 79, 79);
        add_point(-1, -1, -1);
        add_point(-80, -80, -80);
        add_point(-81, 5, 5);
        add_point(-1048576, -1048576, -1048576);
        add_point(1048575, 1048575, 1048575);
        add_point(1048575, -1048576, 0);
        read_slot(0);
        read_slot(4095);
        for (int i = 0; i < 4; i++)
            read_slot(centroid_queue.size() > 0 ? centroid_queue[0].slot : 0);
        drain();
    endtask

    // clustered and scattered points with reads of touched or random slots
    task automatic test_random(int n, int spread);
        int cx;
        int cy;
        int cz;
        int touched[$];
        voxel_result_t r;
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cx = rand_coord();
                cy = rand_coord();
                cz = rand_coord();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                if (touched.size() > 0 && $urandom_range(0, 3) != 0)
                    read_slot(touched[$urandom_range(0, touched.size() - 1)]);
                else
                    read_slot($urandom_range(0, 4095));
            end
            else if ($urandom_range(0, 9) == 0)
                add_point(rand_coord(), rand_coord(), rand_coord());
            else
                add_point(cx + $urandom_range(0, spread) - spread / 2,
                          cy + $urandom_range(0, spread) - spread / 2,
                          cz + $urandom_range(0, spread) - spread / 2);
            r = centroid_queue[$];
            if (r.status <= ST_NEW)
                touched.insert(touched.size(), int'(r.slot));
        end
        drain();
    endtask

    // fill one probe run to force the table-full drop
    task automatic test_full;
        int home;
        int hits;
        int x;
        logic [31:0] h;
        hits = 0;
        x = 0;
        while (hits < PROBES + 2 && x < 2000000)
        begin
            h = mix(mix(x, 0), 0);
            if (h % DEPTH == 100)
            begin
                add_point(x - 1048576 > 1048575 ? 0 : x, 0, 0);
                hits++;
            end
            x++;
            if (x > 1048575)
                break;
        end
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_pressure;
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                add_point($urandom_range(0, 500), 7, 7);
        join
        drain();
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.x_mm = '0;
        in_ch.y_mm = '0;
        in_ch.z_mm = '0;
        in_ch.read_slot = '0;
        out_ch.ready = 1'b0;
        edge_mm = 16'd80;
        vox_total = 0;
        hold_off = 0;
        last_part = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            vox_valid[i] = 0;
            vox_count[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_edge(16'd1);
        test_random(100, 6);
        write_edge(16'd0);
        test_full();
        test_random(40, 4);
        write_edge(16'hFFFF);
        test_random(100, 40000);
        write_edge(16'd333);
        test_pressure();
        test_random(100, 2000);
        write_edge(16'd80);
        last_part = 1;
        test_random(100, 300);
        drain();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // receiver ready with idle bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (!last_part && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        voxel_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (centroid_queue.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = centroid_queue.pop_front();
                if (out_ch.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_ch.status);
                    errors++;
                end
                if (out_ch.slot !== e.slot)
                begin
                    $error("slot exp %0d got %0d", e.slot, out_ch.slot);
                    errors++;
                end
                if (out_ch.point_count !== e.point_count)
                begin
                    $error("point_count exp %0d got %0d", e.point_count, out_ch.point_count);
                    errors++;
                end
                if (out_ch.centroid_x !== e.cx)
                begin
                    $error("centroid_x exp %h got %h", e.cx, out_ch.centroid_x);
                    errors++;
                end
                if (out_ch.centroid_y !== e.cy)
                begin
                    $error("centroid_y exp %h got %h", e.cy, out_ch.centroid_y);
                    errors++;
                end
                if (out_ch.centroid_z !== e.cz)
                begin
                    $error("centroid_z exp %h got %h", e.cz, out_ch.centroid_z);
                    errors++;
                end
                if (out_ch.occupied_voxels !== e.occupied)
                begin
                    $error("occupied_voxels exp %0d got %0d", e.occupied,
                           out_ch.occupied_voxels);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end
endmodule
